@@ sv/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and types of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int MAX_BLOCKS   = 4096;
   localparam int WORD_W       = 64;
   localparam int WORD_COUNT   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int WA_W         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int OFS_W        = $clog2(WORD_W);
   localparam int IDX_W        = WA_W + OFS_W;
   localparam int LIM_W        = IDX_W + 1;
   localparam int CNT_W        = 13;
   localparam int CMP_W        = (LIM_W > CNT_W) ? LIM_W : CNT_W;
   localparam int BLK_W        = 32;
   localparam int CSR_IDX_W    = 1;

   localparam logic [BLK_W-1:0] FDB_RESET    = 32'd1;
   localparam logic [CNT_W-1:0] BLOCKS_RESET = 13'd4096;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef logic [WA_W-1:0]   word_addr_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_DATA_BLOCK = 1'b0,
      CSR_BLOCKS_IN_USE    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_NO_SPACE     = 3'd1,
      STATUS_BLOCK_ZERO   = 3'd2,
      STATUS_RESERVED     = 3'd3,
      STATUS_OUT_OF_RANGE = 3'd4,
      STATUS_DOUBLE_FREE  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC_FIN,
      ST_FREE_CHK,
      ST_FREE_RNG,
      ST_FREE_BIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic          rd_en;
      word_addr_type rd_addr;
      logic          wr_en;
      word_addr_type wr_addr;
      word_type      wr_data;
   } ram_req_type;

endpackage

@@ sv/bba_bitmap_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// Bitmap word store: one write and one read port, registered read data.
// Rows not yet written since reset read as all zero (every block free).
// ----------------------------------------------------------------------------
module bba_bitmap_ram
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ram_req_type ram_req,
   output word_type    rd_data
);

   word_type                mem [WORD_COUNT];
   logic [WORD_COUNT-1:0]   row_vld_ff;
   word_type                rd_word_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_word_ff <= mem[ram_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            row_vld_ff[ram_req.wr_addr] <= 1'b1;
         end
         if (ram_req.rd_en) begin
            rd_vld_ff <= row_vld_ff[ram_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

@@ sv/bba_zero_find.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_zero_find
// Lowest clear bit of one bitmap word among the bits enabled by a mask.
// ----------------------------------------------------------------------------
module bba_zero_find
   import bba_pkg::*;
(
   input  word_type         word,
   input  word_type         mask,
   output logic             found,
   output logic [OFS_W-1:0] offset,
   output word_type         onehot
);

   word_type free_bits;

   always_comb begin
      free_bits = ~word & mask;
      // isolate lowest set bit
      onehot    = free_bits & (~free_bits + word_type'(1));
      found     = |free_bits;
      offset    = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (onehot[i]) begin
            offset = offset | OFS_W'(i);
         end
      end
   end

endmodule

@@ sv/bitmap_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit bitmap block allocator with a used-block counter.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel (valid/ready) carries one request word: allocate or free.
//  - rsp_* channel (valid/ready) returns one word per request: status,
//    granted block (zero unless an allocate succeeds) and the used count.
//  - csr_* port writes first_data_block (index 0) and blocks_in_use (index 1)
//    while no request is in flight, a user rule the block does not enforce.
//  - One request is worked at a time. An allocate reads the bitmap one
//    64-bit word per cycle from the word store until the first free bit,
//    reading at most ceil(count / 64) = 64 words. A free runs its checks,
//    the range check, the read and the write back, and stops early when
//    rejected. The next request is taken the cycle after the response is
//    loaded.
//  - The response sits in an output register; the next request is taken
//    while it waits. A stalled receiver holds the following result back
//    and the block stops taking requests until the output frees up.
//  - Reset empties the bitmap at once (per-row valid bits in the store),
//    zeroes the used count and loads the register defaults.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
   import bba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [BLK_W-1:0]     req_block_number,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [BLK_W-1:0]     rsp_granted_block,
   output logic [CNT_W-1:0]     rsp_used_blocks,

   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BLK_W-1:0]     csr_write_data
);

   state_type          state_ff, state_in;
   logic [BLK_W-1:0]   fdb_ff;
   logic [CNT_W-1:0]   blocks_ff;
   logic [CNT_W-1:0]   used_ff, used_in;

   logic               req_type_ff, req_type_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [LIM_W-1:0]   lim_ff, lim_in;
   word_addr_type      last_word_ff, last_word_in;
   word_type           last_mask_ff, last_mask_in;
   word_addr_type      iss_ff, iss_in;
   logic               iss_done_ff, iss_done_in;
   logic               chk_vld_ff, chk_vld_in;
   word_addr_type      chk_word_ff, chk_word_in;
   logic [BLK_W-1:0]   diff_ff, diff_in;
   logic [IDX_W-1:0]   bit_ff, bit_in;
   status_type         res_status_ff, res_status_in;
   logic [BLK_W-1:0]   res_grant_ff, res_grant_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0]   rsp_grant_ff, rsp_grant_in;
   logic [CNT_W-1:0]   rsp_used_ff, rsp_used_in;

   logic [CMP_W-1:0]   blocks_ext;
   logic [LIM_W-1:0]   lim_calc, lim_m1;
   word_type           last_mask_calc;
   word_type           scan_mask;

   ram_req_type        ram_req;
   word_type           rd_data;
   logic               zf_found;
   logic [OFS_W-1:0]   zf_offset;
   word_type           zf_onehot;

   bba_bitmap_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   bba_zero_find u_find (
      .word   (rd_data),
      .mask   (scan_mask),
      .found  (zf_found),
      .offset (zf_offset),
      .onehot (zf_onehot)
   );

   // effective count = min(blocks_in_use, MAX_BLOCKS)
   assign blocks_ext = CMP_W'(blocks_ff);
   assign lim_calc   = (blocks_ext > CMP_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS)
                                                         : LIM_W'(blocks_ext);
   assign lim_m1     = lim_calc - LIM_W'(1);
   assign last_mask_calc = (lim_calc[OFS_W-1:0] == '0) ? '1 :
      ((word_type'(1) << lim_calc[OFS_W-1:0]) - word_type'(1));
   assign scan_mask  = (chk_word_ff == last_word_ff) ? last_mask_ff : '1;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_block = rsp_grant_ff;
   assign rsp_used_blocks   = rsp_used_ff;

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      req_type_in   = req_type_ff;
      blk_in        = blk_ff;
      lim_in        = lim_ff;
      last_word_in  = last_word_ff;
      last_mask_in  = last_mask_ff;
      iss_in        = iss_ff;
      iss_done_in   = iss_done_ff;
      chk_vld_in    = 1'b0;
      chk_word_in   = chk_word_ff;
      diff_in       = diff_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_used_in   = rsp_used_ff;
      ram_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_type_in   = req_type;
               blk_in        = req_block_number;
               lim_in        = lim_calc;
               last_word_in  = lim_m1[IDX_W-1:OFS_W];
               last_mask_in  = last_mask_calc;
               iss_in        = '0;
               iss_done_in   = 1'b0;
               res_grant_in  = '0;
               res_status_in = STATUS_OK;
               if (req_type == REQ_ALLOC) begin
                  if (lim_calc == '0) begin
                     res_status_in = STATUS_NO_SPACE;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  state_in = ST_FREE_CHK;
               end
            end
         end
         ST_SCAN: begin
            // reads run one word ahead of the check
            if (!iss_done_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = iss_ff;
               iss_in          = iss_ff + WA_W'(1);
               iss_done_in     = (iss_ff == last_word_ff);
            end
            chk_vld_in  = ram_req.rd_en;
            chk_word_in = iss_ff;
            if (chk_vld_ff) begin
               if (zf_found) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = chk_word_ff;
                  ram_req.wr_data = rd_data | zf_onehot;
                  bit_in          = {chk_word_ff, zf_offset};
                  chk_vld_in      = 1'b0;
                  state_in        = ST_ALLOC_FIN;
               end else if (chk_word_ff == last_word_ff) begin
                  res_status_in = STATUS_NO_SPACE;
                  chk_vld_in    = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_ALLOC_FIN: begin
            res_grant_in  = fdb_ff + BLK_W'(bit_ff);
            res_status_in = STATUS_OK;
            used_in       = used_ff + CNT_W'(1);
            state_in      = ST_DONE;
         end
         ST_FREE_CHK: begin
            diff_in = blk_ff - fdb_ff;
            priority if (blk_ff == '0) begin
               res_status_in = STATUS_BLOCK_ZERO;
               state_in      = ST_DONE;
            end else if (blk_ff < fdb_ff) begin
               res_status_in = STATUS_RESERVED;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_FREE_RNG;
            end
         end
         ST_FREE_RNG: begin
            if (diff_ff >= BLK_W'(lim_ff)) begin
               res_status_in = STATUS_OUT_OF_RANGE;
               state_in      = ST_DONE;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = diff_ff[IDX_W-1:OFS_W];
               state_in        = ST_FREE_BIT;
            end
         end
         ST_FREE_BIT: begin
            if (!rd_data[diff_ff[OFS_W-1:0]]) begin
               res_status_in = STATUS_DOUBLE_FREE;
            end else begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = diff_ff[IDX_W-1:OFS_W];
               ram_req.wr_data = rd_data & ~(word_type'(1) << diff_ff[OFS_W-1:0]);
               used_in         = used_ff - CNT_W'(1);
               res_status_in   = STATUS_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_grant_in  = res_grant_ff;
               rsp_used_in   = used_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         iss_done_ff  <= 1'b0;
         chk_vld_ff   <= 1'b0;
         fdb_ff       <= FDB_RESET;
         blocks_ff    <= BLOCKS_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_done_ff  <= iss_done_in;
         chk_vld_ff   <= chk_vld_in;
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_FIRST_DATA_BLOCK: fdb_ff    <= csr_write_data;
               CSR_BLOCKS_IN_USE:    blocks_ff <= csr_write_data[CNT_W-1:0];
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      blk_ff        <= blk_in;
      lim_ff        <= lim_in;
      last_word_ff  <= last_word_in;
      last_mask_ff  <= last_mask_in;
      iss_ff        <= iss_in;
      chk_word_ff   <= chk_word_in;
      diff_ff       <= diff_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // a bitmap write changes exactly one bit of the word read
   assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> $countones(ram_req.wr_data ^ rd_data) == 1)
      else $error("bitmap write changes other than one bit");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_vld_ff) |-> chk_word_ff <= last_word_ff)
      else $error("scan past last bitmap word");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ALLOC_FIN |=> used_ff == $past(used_ff) + CNT_W'(1))
      else $error("used count not bumped on grant");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

   assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= 32'(MAX_BLOCKS))
      else $error("used count above bitmap size");

   // request type is kept for debug visibility of the item in flight
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> req_type_ff == REQ_ALLOC)
      else $error("scan running for a free request");

endmodule
